// File: rtl/core/ira_pkg.sv
package ira_pkg;

    localparam int SAMPLE_WIDTH = 16;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_UP2   = 2'd1,
        MODE_DOWN3 = 2'd2,
        MODE_DOWN2 = 2'd3
    } mode_t;

endpackage

// File: rtl/core/integer_ratio_audio_resampler_top.sv
// registered: an input request's first result is shown in the cycle after the input is accepted
// throughput: one input request per cycle when it causes at most one result and out_stall is low;
//   in 2x upsampling a new input stalls until the previous input's last result (of up to three at a chunk end)
//   is taken from the three-entry result buffer through the single result port
// reset: asynchronous active-low rst_n clears mode (pass through) and chunk state and empties the result buffer
module integer_ratio_audio_resampler_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  ira_pkg::sample_t sample_in,
    input  logic             chunk_end,
    output logic             out_valid,
    input  logic             out_stall,
    output ira_pkg::sample_t sample_out,
    output logic             last_of_run
);
    import ira_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int SUM_W = SW + 2;
    localparam logic [SW+1:0] ONE_WIDE   = 1;
    localparam logic [SW+1:0] RECIP_WIDE =
        ((ONE_WIDE << (SW + 1)) + (SW+2)'(2)) / (SW+2)'(3);
    localparam logic [SW:0] DIV3_RECIP = RECIP_WIDE[SW:0];

    mode_t                    mode_reg;
    sample_t                  prev_reg,  prev_next;
    logic                     have_prev_reg, have_prev_next;
    logic [1:0]               phase_reg, phase_next;
    logic signed [SUM_W-1:0]  sum_reg,   sum_next;
    sample_t                  res_reg [3];
    sample_t                  res_next [3];
    logic [1:0]               rem_reg,   rem_next;

    logic                     cfg_we;
    logic                     in_acc;
    logic                     out_take;

    logic signed [SW:0]       pair_sum;
    logic signed [SW:0]       pair_adj;
    sample_t                  avg;
    logic signed [SUM_W-1:0]  tri_sum;
    logic                     tri_neg;
    logic [SUM_W-1:0]         tri_abs;
    logic [2*SW+1:0]          tri_prod;
    logic [SW:0]              tri_q;
    sample_t                  tri_mean;

    sample_t                  load [3];
    logic [1:0]               load_cnt;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign out_valid = rem_reg != 2'd0;
    assign out_take  = out_valid && !out_stall;
    assign in_stall  = !((rem_reg == 2'd0) || ((rem_reg == 2'd1) && !out_stall));
    assign in_acc    = in_valid && !in_stall;

    assign sample_out  = res_reg[0];
    assign last_of_run = rem_reg == 2'd1;

    // truncated mean of neighbours
    assign pair_sum = (SW+1)'(prev_reg) + (SW+1)'(sample_in);
    assign pair_adj = pair_sum + {{SW{1'b0}}, pair_sum[SW]};
    assign avg      = pair_adj[SW:1];

    // triple mean, divide by three through reciprocal multiply
    assign tri_sum  = sum_reg + SUM_W'(sample_in);
    assign tri_neg  = tri_sum[SUM_W-1];
    assign tri_abs  = tri_neg ? SUM_W'(-tri_sum) : SUM_W'(tri_sum);
    assign tri_prod = tri_abs[SW:0] * DIV3_RECIP;
    assign tri_q    = tri_prod[2*SW+1:SW+1];
    assign tri_mean = tri_neg ? sample_t'(-tri_q[SW-1:0]) : sample_t'(tri_q[SW-1:0]);

    always_comb
    begin
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        load[0]        = sample_in;
        load[1]        = sample_in;
        load[2]        = sample_in;
        load_cnt       = 2'd0;

        unique case (mode_reg)
            MODE_PASS:
            begin
                load_cnt = 2'd1;
            end
            MODE_UP2:
            begin
                if (have_prev_reg)
                begin
                    load[0]  = avg;
                    load_cnt = chunk_end ? 2'd3 : 2'd2;
                end
                else
                begin
                    load_cnt = chunk_end ? 2'd2 : 2'd1;
                end
                prev_next      = sample_in;
                have_prev_next = 1'b1;
            end
            MODE_DOWN3:
            begin
                if (phase_reg >= 2'd2)
                begin
                    load[0]    = tri_mean;
                    load_cnt   = 2'd1;
                    sum_next   = '0;
                    phase_next = 2'd0;
                end
                else
                begin
                    sum_next   = tri_sum;
                    phase_next = phase_reg + 2'd1;
                end
            end
            MODE_DOWN2:
            begin
                if (phase_reg == 2'd0)
                begin
                    prev_next  = sample_in;
                    phase_next = 2'd1;
                end
                else
                begin
                    load[0]    = prev_reg;
                    load_cnt   = 2'd1;
                    phase_next = 2'd0;
                end
            end
            default:
            begin
                load_cnt = 2'd0;
            end
        endcase

        if (chunk_end)
        begin
            prev_next      = '0;
            have_prev_next = 1'b0;
            phase_next     = 2'd0;
            sum_next       = '0;
        end

        res_next[0] = res_reg[1];
        res_next[1] = res_reg[2];
        res_next[2] = res_reg[2];
        rem_next    = out_take ? rem_reg - 2'd1 : rem_reg;
        if (in_acc)
        begin
            res_next = load;
            rem_next = load_cnt;
        end
        else if (!out_take)
        begin
            res_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PASS;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            phase_reg     <= 2'd0;
            sum_reg       <= '0;
            rem_reg       <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            if (cfg_we)
            begin
                mode_reg      <= mode_t'(cfg_data);
                prev_reg      <= '0;
                have_prev_reg <= 1'b0;
                phase_reg     <= 2'd0;
                sum_reg       <= '0;
            end
            else if (in_acc)
            begin
                prev_reg      <= prev_next;
                have_prev_reg <= have_prev_next;
                phase_reg     <= phase_next;
                sum_reg       <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("group phase out of range");

    a_pair_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_DOWN2) |-> (phase_reg <= 2'd1))
        else $error("pair phase out of range");

    a_pass_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !cfg_we && mode_reg == MODE_PASS) |=>
            (out_valid && last_of_run && sample_out == $past(sample_in)))
        else $error("pass through result wrong");

    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (!have_prev_reg && phase_reg == 2'd0 && sum_reg == '0))
        else $error("chunk state not cleared on mode write");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(sample_out)))
        else $error("stalled result lost");

endmodule
